FILE: design/hrpp_pkg.sv
// Shared types and constants for the H.264 RTP packetization planner.
// Used by the register block, the shared arithmetic unit and the top-level sequencer.
`timescale 1ns / 1ps

package hrpp_pkg;

  // Input transaction: one NAL unit descriptor
  typedef struct packed {
    logic [15:0] nal_length;
    logic [7:0]  nal_header;
    logic        last_nal;
  } nal_item_t;

  // Output transaction: one RTP packet descriptor
  typedef struct packed {
    logic [1:0]  packet_kind;
    logic [7:0]  first_nal;
    logic [8:0]  nal_count;
    logic [15:0] fragment_offset;
    logic [15:0] payload_bytes;
    logic [7:0]  fu_ind_byte;
    logic [7:0]  fu_hdr_byte;
    logic [11:0] packet_bytes;
    logic        last_of_run;
  } pkt_item_t;

  // Shared adder/subtractor operand width
  localparam int ALU_W = 18;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             neg;   // subtraction went below zero
    logic             zero;
    logic             lt;    // sum below packet limit
    logic             eq;
    logic             gt;
  } alu_res_t;

  // Packet kinds
  localparam logic [1:0] KIND_SINGLE = 2'd0;
  localparam logic [1:0] KIND_STAP   = 2'd1;
  localparam logic [1:0] KIND_FU     = 2'd2;

  localparam logic [4:0]  FU_A_TYPE        = 5'd28;
  localparam logic [11:0] RTP_HEADER_BYTES = 12'd12;
  localparam logic [11:0] FU_OVERHEAD      = 12'd14;  // RTP header + FU indicator + FU header
  localparam logic [11:0] MIN_PACKET       = 12'd64;
  localparam logic [11:0] MAX_PACKET_RESET = 12'd1400;
  localparam logic [8:0]  GROUP_LAST_FILL  = 9'd255;  // joining makes the group 256 NALs
  localparam logic [5:0]  MAX_RESULTS      = 6'd49;

  // Configuration port
  localparam int          APB_AW           = 2;
  localparam logic [1:0]  ADDR_MAX_PACKET  = 2'd0;

endpackage

FILE: design/hrpp_cfg.sv
// APB-style configuration register for the packet size limit.
// Holds max_packet_bytes and presents the effective limit (floored at 64). Uses hrpp_pkg.
`timescale 1ns / 1ps

module hrpp_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hrpp_pkg::APB_AW-1:0]    paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output logic [11:0]                    limit
);
  import hrpp_pkg::*;

  logic [11:0] max_packet_bytes;

  assign pready = 1'b1;

  // Only one register: every write lands in it
  always_ff @(posedge clk) begin
    if (rst) begin
      max_packet_bytes <= MAX_PACKET_RESET;
    end else if (psel && penable && pwrite) begin
      max_packet_bytes <= pwdata[11:0];
    end
  end

  assign prdata = (paddr == ADDR_MAX_PACKET) ? {20'd0, max_packet_bytes} : 32'd0;
  assign limit  = (max_packet_bytes < MIN_PACKET) ? MIN_PACKET : max_packet_bytes;

endmodule

FILE: design/hrpp_alu.sv
// Shared add/subtract unit with compare against the packet limit.
// One operation per cycle, operands chosen by the sequencer. Uses hrpp_pkg.
`timescale 1ns / 1ps

module hrpp_alu (
  input  logic [hrpp_pkg::ALU_W-1:0] a,
  input  logic [hrpp_pkg::ALU_W-1:0] b,
  input  logic                       sub,
  input  logic [11:0]                limit,
  output hrpp_pkg::alu_res_t         res
);
  import hrpp_pkg::*;

  logic [ALU_W:0] full;

  always_comb begin
    if (sub) begin
      full = {1'b0, a} - {1'b0, b};
    end else begin
      full = {1'b0, a} + {1'b0, b};
    end
    res.sum  = full[ALU_W-1:0];
    res.neg  = sub & full[ALU_W];
    res.zero = (full[ALU_W-1:0] == '0);
    res.lt   = (full[ALU_W-1:0] <  ALU_W'(limit));
    res.eq   = (full[ALU_W-1:0] == ALU_W'(limit));
    res.gt   = (full[ALU_W-1:0] >  ALU_W'(limit));
  end

endmodule

FILE: design/h264_rtp_packetization_planner.sv
// Each NAL is accepted in S_IDLE and compared against the pending group in S_DECIDE,
// which emits a STAP-A when the NAL closes the group; a single-NAL packet or a flushed
// group goes out from S_SOLO, and an FU-A NAL passes S_SOLO and S_FMAX before S_FRAG emits
// one fragment per cycle while the output does not stall. nal_stall holds new NALs off
// until the item is finished, since one shared add/compare unit serves every step.
// rst (synchronous) clears the group and frame index and restores the limit to its reset value.
`timescale 1ns / 1ps

module h264_rtp_packetization_planner #(
  parameter int MAX_NALS_PER_FRAME = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  // NAL descriptor input
  input  logic                         nal_valid,
  output logic                         nal_stall,
  input  hrpp_pkg::nal_item_t          nal,
  // packet descriptor output
  output logic                         pkt_valid,
  input  logic                         pkt_stall,
  output hrpp_pkg::pkt_item_t          pkt,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hrpp_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import hrpp_pkg::*;

  localparam int IDXW = (MAX_NALS_PER_FRAME > 1) ? $clog2(MAX_NALS_PER_FRAME) : 1;
  localparam logic [IDXW-1:0] IDX_LAST = IDXW'(MAX_NALS_PER_FRAME - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_SOLO   = 3'd2;
  localparam logic [2:0] S_FMAX   = 3'd3;
  localparam logic [2:0] S_FRAG   = 3'd4;

  logic [11:0] limit;
  hrpp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit   (limit)
  );

  logic [ALU_W-1:0] alu_a, alu_b;
  logic             alu_sub;
  alu_res_t         alu;

  hrpp_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .limit (limit),
    .res   (alu)
  );

  // Control state
  logic [2:0]      state, state_next;
  logic [IDXW-1:0] frame_idx, frame_idx_next;
  logic [8:0]      pending_count, pending_count_next;
  logic [15:0]     pending_bytes, pending_bytes_next;
  logic [7:0]      pending_first, pending_first_next;
  logic [12:0]     group_cost, group_cost_next;   // packet size if one more NAL of length 0 joins
  logic [5:0]      res_count, res_count_next;
  logic            flush_owed, flush_owed_next;   // pending group must go out before this NAL

  // Per-item working registers
  logic [15:0]     len_q, len_next;
  logic [7:0]      hdr_q, hdr_next;
  logic            last_q, last_next;
  logic [IDXW-1:0] idx_q, idx_next;
  logic [15:0]     rem, rem_next;
  logic [15:0]     offset, offset_next;
  logic [11:0]     fmax, fmax_next;
  logic            start_flag, start_flag_next;

  logic            emit, out_free, accept, frag_fin;
  logic [15:0]     take;
  logic [7:0]      idx8;
  pkt_item_t       pkt_new;

  assign nal_stall = (state != S_IDLE);
  assign accept    = nal_valid && !nal_stall;
  assign out_free  = !pkt_valid || !pkt_stall;
  assign idx8      = 8'(idx_q);
  assign frag_fin  = alu.neg || alu.zero;
  assign take      = frag_fin ? rem : 16'(fmax);

  // operand select for the shared unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state)
      S_DECIDE: begin
        alu_a = ALU_W'(group_cost);
        alu_b = ALU_W'(len_q);
      end
      S_SOLO: begin
        alu_a = ALU_W'(len_q);
        alu_b = ALU_W'(RTP_HEADER_BYTES);
      end
      S_FMAX: begin
        alu_a   = ALU_W'(limit);
        alu_b   = ALU_W'(FU_OVERHEAD);
        alu_sub = 1'b1;
      end
      S_FRAG: begin
        alu_a   = ALU_W'(rem);
        alu_b   = ALU_W'(fmax);
        alu_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next         = state;
    frame_idx_next     = frame_idx;
    pending_count_next = pending_count;
    pending_bytes_next = pending_bytes;
    pending_first_next = pending_first;
    group_cost_next    = group_cost;
    res_count_next     = res_count;
    flush_owed_next    = flush_owed;
    len_next           = len_q;
    hdr_next           = hdr_q;
    last_next          = last_q;
    idx_next           = idx_q;
    rem_next           = rem;
    offset_next        = offset;
    fmax_next          = fmax;
    start_flag_next    = start_flag;
    emit               = 1'b0;
    pkt_new            = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          len_next       = nal.nal_length;
          hdr_next       = nal.nal_header;
          last_next      = nal.last_nal;
          idx_next       = frame_idx;
          res_count_next = '0;
          if (nal.last_nal || frame_idx == IDX_LAST) begin
            frame_idx_next = '0;
          end else begin
            frame_idx_next = frame_idx + 1'b1;
          end
          state_next = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (pending_count == '0) begin
          state_next = S_SOLO;
        end else if (alu.eq ||
                     (alu.lt && (last_q || pending_count >= GROUP_LAST_FILL))) begin
          // group plus this NAL goes out as one STAP-A
          emit                = 1'b1;
          pkt_new.packet_kind = KIND_STAP;
          pkt_new.first_nal   = pending_first;
          pkt_new.nal_count   = pending_count + 9'd1;
          pkt_new.payload_bytes = pending_bytes + len_q;
          pkt_new.packet_bytes  = alu.sum[11:0];
          pkt_new.last_of_run   = 1'b1;
          if (out_free) begin
            pending_count_next = '0;
            pending_bytes_next = '0;
            pending_first_next = '0;
            res_count_next     = res_count + 6'd1;
            state_next         = S_IDLE;
          end
        end else if (alu.gt) begin
          // group goes out from S_SOLO, where this NAL's outcome is known
          flush_owed_next = 1'b1;
          state_next      = S_SOLO;
        end else begin
          pending_count_next = pending_count + 9'd1;
          pending_bytes_next = pending_bytes + len_q;
          group_cost_next    = 13'(alu.sum + ALU_W'(2));
          state_next         = S_IDLE;
        end
      end

      S_SOLO: begin
        if (flush_owed) begin
          emit                  = 1'b1;
          pkt_new.first_nal     = pending_first;
          pkt_new.payload_bytes = pending_bytes;
          if (pending_count == 9'd1) begin
            pkt_new.packet_kind  = KIND_SINGLE;
            pkt_new.nal_count    = 9'd1;
            pkt_new.packet_bytes = 12'(pending_bytes + 16'(RTP_HEADER_BYTES));
          end else begin
            pkt_new.packet_kind  = KIND_STAP;
            pkt_new.nal_count    = pending_count;
            pkt_new.packet_bytes = 12'(group_cost - 13'd2);
          end
          // the flush closes the run only when this NAL becomes the new group
          pkt_new.last_of_run = alu.lt && !last_q;
          if (out_free) begin
            pending_count_next = '0;
            pending_bytes_next = '0;
            pending_first_next = '0;
            res_count_next     = res_count + 6'd1;
            flush_owed_next    = 1'b0;
          end
        end else if (alu.eq || (alu.lt && last_q)) begin
          emit                  = 1'b1;
          pkt_new.packet_kind   = KIND_SINGLE;
          pkt_new.first_nal     = idx8;
          pkt_new.nal_count     = 9'd1;
          pkt_new.payload_bytes = len_q;
          pkt_new.packet_bytes  = alu.sum[11:0];
          pkt_new.last_of_run   = 1'b1;
          if (out_free) begin
            res_count_next = res_count + 6'd1;
            state_next     = S_IDLE;
          end
        end else if (alu.gt) begin
          rem_next   = len_q - 16'd1;
          state_next = S_FMAX;
        end else begin
          pending_count_next = 9'd1;
          pending_bytes_next = len_q;
          pending_first_next = idx8;
          // 13 + len + 2 * 2, i.e. size + 5
          group_cost_next    = 13'(alu.sum + ALU_W'(5));
          state_next         = S_IDLE;
        end
      end

      S_FMAX: begin
        fmax_next       = alu.sum[11:0];
        offset_next     = '0;
        start_flag_next = 1'b1;
        state_next      = S_FRAG;
      end

      S_FRAG: begin
        emit                    = 1'b1;
        pkt_new.packet_kind     = KIND_FU;
        pkt_new.first_nal       = idx8;
        pkt_new.nal_count       = 9'd1;
        pkt_new.fragment_offset = offset;
        pkt_new.payload_bytes   = take;
        pkt_new.fu_ind_byte     = {hdr_q[7:5], FU_A_TYPE};
        pkt_new.fu_hdr_byte     = {start_flag, frag_fin, 1'b0, hdr_q[4:0]};
        pkt_new.packet_bytes    = 12'(take + 16'(FU_OVERHEAD));
        pkt_new.last_of_run     = frag_fin || (res_count == MAX_RESULTS - 6'd1);
        if (out_free) begin
          rem_next        = alu.sum[15:0];
          offset_next     = offset + take;
          start_flag_next = 1'b0;
          res_count_next  = res_count + 6'd1;
          if (pkt_new.last_of_run) begin
            state_next = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      frame_idx     <= '0;
      pending_count <= '0;
      pending_bytes <= '0;
      pending_first <= '0;
      group_cost    <= '0;
      res_count     <= '0;
      flush_owed    <= 1'b0;
      pkt_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      frame_idx     <= frame_idx_next;
      pending_count <= pending_count_next;
      pending_bytes <= pending_bytes_next;
      pending_first <= pending_first_next;
      group_cost    <= group_cost_next;
      res_count     <= res_count_next;
      flush_owed    <= flush_owed_next;
      if (emit && out_free) begin
        pkt_valid <= 1'b1;
      end else if (!pkt_stall) begin
        pkt_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    len_q      <= len_next;
    hdr_q      <= hdr_next;
    last_q     <= last_next;
    idx_q      <= idx_next;
    rem        <= rem_next;
    offset     <= offset_next;
    fmax       <= fmax_next;
    start_flag <= start_flag_next;
    if (emit && out_free) begin
      pkt <= pkt_new;
    end
  end

  // A held group never reaches 256 NALs; the full-group rule sends it first
  a_group_bound: assert property (@(posedge clk) disable iff (rst)
    pending_count <= GROUP_LAST_FILL)
    else $error("pending group count out of range");

  // An empty group carries no bytes
  a_group_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && pending_count == '0) |-> pending_bytes == '0)
    else $error("empty group holds bytes");

  // Results per item stay within the cap
  a_result_cap: assert property (@(posedge clk) disable iff (rst)
    res_count <= MAX_RESULTS)
    else $error("too many results for one item");

  // Fragment size is at least limit floor minus FU overhead
  a_frag_size: assert property (@(posedge clk) disable iff (rst)
    state == S_FRAG |-> fmax >= (MIN_PACKET - FU_OVERHEAD))
    else $error("fragment size below floor");

  // A fragment run starts with the start bit set
  a_frag_start: assert property (@(posedge clk) disable iff (rst)
    (state == S_FMAX) |=> (state == S_FRAG && start_flag))
    else $error("fragment run without start bit");

endmodule
